### hdl/cp2rgb_pkg.sv
// shared types, format codes and queue sizes for the camera pixel converter
package cp2rgb_pkg;

    localparam logic [2:0] FMT_RGB    = 3'd0;
    localparam logic [2:0] FMT_YUYV   = 3'd1;
    localparam logic [2:0] FMT_UYVY   = 3'd2;
    localparam logic [2:0] FMT_YUV444 = 3'd3;
    localparam logic [2:0] FMT_BAYER  = 3'd4;

    localparam int JQ_DEPTH = 4;
    localparam int JQ_AW    = $clog2(JQ_DEPTH);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_item;
    } t_out_item;

    // one pixel of work: either ready rgb bytes or a y/u/v triple
    typedef struct packed {
        logic       is_yuv;
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
        logic       last;
    } t_job;

endpackage

### hdl/camera_pixel_to_rgb888.sv
// camera pixel group to rgb888 converter, top level
// an item passes the front job register, job queue, multiply stage and result queue
// throughput: one result pixel per cycle while the output is popped, set by the single
//   job issue port of the back end; 4:2:2 items give two jobs, rgb, yuv444 and bayer one
// reset: synchronous active-low i_rst_n empties both queues and sets the format to rgb
module camera_pixel_to_rgb888 (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_wr_data,
    input  logic                  push,
    output logic                  full,
    input  cp2rgb_pkg::t_in_item  i_item,
    output logic                  empty,
    input  logic                  pop,
    output cp2rgb_pkg::t_out_item o_pixel
);

    logic             job_valid;
    cp2rgb_pkg::t_job job_in;
    logic             jq_full;
    logic             jq_empty;
    logic             jq_pop;
    cp2rgb_pkg::t_job job_head;

    cp2rgb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_item        (i_item),
        .o_job_valid   (job_valid),
        .o_job         (job_in),
        .i_job_full    (jq_full)
    );

    cp2rgb_job_q u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job_in),
        .o_full  (jq_full),
        .i_pop   (jq_pop),
        .o_empty (jq_empty),
        .o_job   (job_head)
    );

    cp2rgb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (jq_empty),
        .i_job       (job_head),
        .o_job_pop   (jq_pop),
        .empty       (empty),
        .pop         (pop),
        .o_pixel     (o_pixel)
    );

endmodule

### hdl/cp2rgb_front.sv
// front end: format register, item decode and per-pixel job issue
module cp2rgb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_wr_data,
    input  logic                  push,
    output logic                  full,
    input  cp2rgb_pkg::t_in_item  i_item,
    output logic                  o_job_valid,
    output cp2rgb_pkg::t_job      o_job,
    input  logic                  i_job_full
);

    logic [2:0]       r_fmt;
    logic [1:0]       r_pend;
    logic [1:0]       n_pend;
    cp2rgb_pkg::t_job r_job_a;
    cp2rgb_pkg::t_job r_job_b;
    cp2rgb_pkg::t_job n_job_a;
    cp2rgb_pkg::t_job n_job_b;
    cp2rgb_pkg::t_job dec_a;
    cp2rgb_pkg::t_job dec_b;
    logic [1:0]       dec_cnt;
    logic [8:0]       green_sum;
    logic             emit;
    logic             accept;

    assign green_sum = {1'b0, i_item.byte0} + {1'b0, i_item.byte3};

    always_comb begin
        dec_a   = '0;
        dec_b   = '0;
        dec_cnt = 2'd0;
        case (r_fmt)
            cp2rgb_pkg::FMT_RGB: begin
                dec_a   = '{1'b0, i_item.byte0, i_item.byte1, i_item.byte2, 1'b1};
                dec_cnt = 2'd1;
            end
            cp2rgb_pkg::FMT_YUYV: begin
                dec_a   = '{1'b1, i_item.byte0, i_item.byte1, i_item.byte3, 1'b0};
                dec_b   = '{1'b1, i_item.byte2, i_item.byte1, i_item.byte3, 1'b1};
                dec_cnt = 2'd2;
            end
            cp2rgb_pkg::FMT_UYVY: begin
                dec_a   = '{1'b1, i_item.byte1, i_item.byte0, i_item.byte2, 1'b0};
                dec_b   = '{1'b1, i_item.byte3, i_item.byte0, i_item.byte2, 1'b1};
                dec_cnt = 2'd2;
            end
            cp2rgb_pkg::FMT_YUV444: begin
                dec_a   = '{1'b1, i_item.byte0, i_item.byte1, i_item.byte2, 1'b1};
                dec_cnt = 2'd1;
            end
            cp2rgb_pkg::FMT_BAYER: begin
                dec_a   = '{1'b0, i_item.byte1, green_sum[8:1], i_item.byte2, 1'b1};
                dec_cnt = 2'd1;
            end
            default: begin
                // unused codes swallow the item
                dec_cnt = 2'd0;
            end
        endcase
    end

    assign emit        = (r_pend != 2'd0) && !i_job_full;
    assign full        = !((r_pend == 2'd0) || ((r_pend == 2'd1) && emit));
    assign accept      = push && !full;
    assign o_job_valid = emit;
    assign o_job       = r_job_a;

    always_comb begin
        n_pend  = r_pend;
        n_job_a = r_job_a;
        n_job_b = r_job_b;
        if (accept) begin
            n_pend  = dec_cnt;
            n_job_a = dec_a;
            n_job_b = dec_b;
        end else if (emit) begin
            if (r_pend == 2'd2) begin
                n_pend  = 2'd1;
                n_job_a = r_job_b;
            end else begin
                n_pend = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= cp2rgb_pkg::FMT_RGB;
            r_pend <= 2'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_fmt <= i_cfg_wr_data;
            end
            r_pend <= n_pend;
        end
        r_job_a <= n_job_a;
        r_job_b <= n_job_b;
    end

endmodule

### hdl/cp2rgb_job_q.sv
// small register queue of pixel jobs between front and back
module cp2rgb_job_q (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cp2rgb_pkg::t_job i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output cp2rgb_pkg::t_job o_job
);

    cp2rgb_pkg::t_job               r_mem [cp2rgb_pkg::JQ_DEPTH];
    logic [cp2rgb_pkg::JQ_AW-1:0]   r_wr_ptr;
    logic [cp2rgb_pkg::JQ_AW-1:0]   r_rd_ptr;
    logic [cp2rgb_pkg::JQ_AW:0]     r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == (cp2rgb_pkg::JQ_AW + 1)'(cp2rgb_pkg::JQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + cp2rgb_pkg::JQ_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + cp2rgb_pkg::JQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (cp2rgb_pkg::JQ_AW + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (cp2rgb_pkg::JQ_AW + 1)'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

### hdl/cp2rgb_back.sv
// back end: bt.601 multiply stage, sum and clamp, result queue
module cp2rgb_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_empty,
    input  cp2rgb_pkg::t_job      i_job,
    output logic                  o_job_pop,
    output logic                  empty,
    input  logic                  pop,
    output cp2rgb_pkg::t_out_item o_pixel
);

    logic signed [19:0] c_val;
    logic signed [19:0] d_val;
    logic signed [19:0] e_val;

    logic               r_s1_valid;
    logic               r_s1_yuv;
    logic [7:0]         r_s1_ch0;
    logic [7:0]         r_s1_ch1;
    logic [7:0]         r_s1_ch2;
    logic               r_s1_last;
    logic signed [19:0] r_s1_yc;
    logic signed [19:0] r_s1_er;
    logic signed [19:0] r_s1_dg;
    logic signed [19:0] r_s1_eg;
    logic signed [19:0] r_s1_db;

    logic signed [19:0]    sum_r;
    logic signed [19:0]    sum_g;
    logic signed [19:0]    sum_b;
    cp2rgb_pkg::t_out_item px;

    cp2rgb_pkg::t_out_item          r_oq [cp2rgb_pkg::OQ_DEPTH];
    logic [cp2rgb_pkg::OQ_AW-1:0]   r_wr_ptr;
    logic [cp2rgb_pkg::OQ_AW-1:0]   r_rd_ptr;
    logic [cp2rgb_pkg::OQ_AW:0]     r_count;
    logic [cp2rgb_pkg::OQ_AW+1:0]   in_use;
    logic                           do_pop;

    function automatic logic [7:0] clamp_byte(input logic signed [19:0] sum);
        logic signed [11:0] sh;
        logic [7:0]         res;
        sh = sum[19:8];
        if (sh[11]) begin
            res = 8'd0;
        end else if (sh[10:8] != 3'd0) begin
            res = 8'd255;
        end else begin
            res = sh[7:0];
        end
        return res;
    endfunction

    // a job issues only if the result queue has a slot for it and the one in flight
    assign in_use    = {1'b0, r_count} + {{(cp2rgb_pkg::OQ_AW + 1){1'b0}}, r_s1_valid};
    assign o_job_pop = !i_job_empty &&
                       (in_use < (cp2rgb_pkg::OQ_AW + 2)'(cp2rgb_pkg::OQ_DEPTH));

    assign c_val = $signed({12'd0, i_job.ch0}) - 20'sd16;
    assign d_val = $signed({12'd0, i_job.ch1}) - 20'sd128;
    assign e_val = $signed({12'd0, i_job.ch2}) - 20'sd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_job_pop;
        end
        if (o_job_pop) begin
            r_s1_yuv  <= i_job.is_yuv;
            r_s1_ch0  <= i_job.ch0;
            r_s1_ch1  <= i_job.ch1;
            r_s1_ch2  <= i_job.ch2;
            r_s1_last <= i_job.last;
            r_s1_yc   <= c_val * 20'sd298;
            r_s1_er   <= e_val * 20'sd409;
            r_s1_dg   <= d_val * 20'sd100;
            r_s1_eg   <= e_val * 20'sd209;
            r_s1_db   <= d_val * 20'sd516;
        end
    end

    assign sum_r = r_s1_yc + r_s1_er + 20'sd128;
    assign sum_g = r_s1_yc - r_s1_dg - r_s1_eg + 20'sd128;
    assign sum_b = r_s1_yc + r_s1_db + 20'sd128;

    always_comb begin
        px.last_of_item = r_s1_last;
        if (r_s1_yuv) begin
            px.red   = clamp_byte(sum_r);
            px.green = clamp_byte(sum_g);
            px.blue  = clamp_byte(sum_b);
        end else begin
            px.red   = r_s1_ch0;
            px.green = r_s1_ch1;
            px.blue  = r_s1_ch2;
        end
    end

    assign empty   = (r_count == '0);
    assign o_pixel = r_oq[r_rd_ptr];
    assign do_pop  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (r_s1_valid) begin
                r_wr_ptr <= r_wr_ptr + cp2rgb_pkg::OQ_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + cp2rgb_pkg::OQ_AW'(1);
            end
            if (r_s1_valid && !do_pop) begin
                r_count <= r_count + (cp2rgb_pkg::OQ_AW + 1)'(1);
            end else if (do_pop && !r_s1_valid) begin
                r_count <= r_count - (cp2rgb_pkg::OQ_AW + 1)'(1);
            end
        end
        if (r_s1_valid) begin
            r_oq[r_wr_ptr] <= px;
        end
    end

endmodule
